### rtl/tpc_pkg.sv
`timescale 1ns / 1ps

package tpc_pkg;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_DIV,
        SEQ_MUL_AT,
        SEQ_MUL_HT,
        SEQ_MUL_VT
    } seq_state_t;

    typedef enum logic [1:0] {
        SEG_ACCEL  = 2'd0,
        SEG_CRUISE = 2'd1,
        SEG_DECEL  = 2'd2,
        SEG_DONE   = 2'd3
    } segment_t;

    localparam logic [2:0] REG_START = 3'd0;
    localparam logic [2:0] REG_END   = 3'd1;
    localparam logic [2:0] REG_VEL   = 3'd2;
    localparam logic [2:0] REG_ACC   = 3'd3;
    localparam logic [2:0] REG_TOTAL = 3'd4;

    localparam logic [30:0] VEL_RESET   = 31'd65536;
    localparam logic [30:0] ACC_RESET   = 31'd65536;
    localparam logic [31:0] TOTAL_RESET = 32'd262144;
    localparam logic [32:0] TA_RESET    = 33'd65536;
    localparam logic [33:0] TC_RESET    = 34'd131072;
    localparam logic [59:0] HTA_RESET   = 60'd32768;
    localparam logic [50:0] VTC_RESET   = 51'd131072;

    localparam logic [32:0] TA_MAX   = {33{1'b1}};
    localparam logic [60:0] PROD_LIM = {1'b1, 60'd0};

    // dividend v << 16 is 47 bits, multiplier operand y is 34 bits
    localparam logic [5:0] DIV_LAST = 6'd46;
    localparam logic [5:0] MUL_LAST = 6'd33;

    function automatic logic [60:0] sat60(input logic [78:0] x);
        logic [60:0] r;
        if (x > {18'd0, PROD_LIM})
            r = PROD_LIM;
        else
            r = x[60:0];
        return r;
    endfunction

endpackage

### rtl/trapezoidal_trajectory_position_core.sv
`timescale 1ns / 1ps

// Channel   | Handshake             | Payload
// ----------+-----------------------+---------------------------------------
// input     | in_valid / in_stall   | sample_time[31:0]
// output    | out_valid / out_stall | position[31:0] signed, segment[1:0]
// config    | cfg_write             | cfg_index[2:0], cfg_data[31:0]
//
// Seven register stages, one sample per cycle while in_stall and out_stall are low.
// A write to a defined register restarts a derivation sequencer: a 47-step
// restoring divider for v/a, then three 34-step serial multiplies (a*ta*ta/2
// and v*tc), during which in_stall is high. Reset loads the derived values
// for the reset registers directly. Each stage holds only while it is full
// and the stage after it holds, so bubbles close up under out_stall.
module trapezoidal_trajectory_position_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        sample_time,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] position,
    output logic [1:0]         segment
);

    // configuration and derived values
    logic signed [31:0] start_reg, end_reg;
    logic [30:0]        vel_reg, acc_reg;
    logic [31:0]        total_reg;
    logic [32:0]        ta_reg, ta_next;
    logic signed [33:0] tc_reg, tc_next;
    logic [59:0]        hta_reg, hta_next;
    logic signed [50:0] vtc_reg, vtc_next;

    // sequencer
    tpc_pkg::seq_state_t state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [30:0] rem_reg, rem_next;
    logic [46:0] quo_reg, quo_next;
    logic [60:0] mx_reg, mx_next;
    logic [33:0] my_reg, my_next;
    logic [94:0] prod_reg, prod_next;

    logic        busy;
    logic        cfg_hit;
    logic [46:0] dividend;
    logic [5:0]  div_bit;
    logic [31:0] rem_shift;
    logic        quo_bit;
    logic [32:0] ta_calc;
    logic signed [34:0] tc_wide;
    logic [60:0] p_sat;
    logic [78:0] vt_mag;

    assign busy    = (state_reg != tpc_pkg::SEQ_IDLE);
    assign cfg_hit = cfg_write && (cfg_index <= tpc_pkg::REG_TOTAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= '0;
            vel_reg   <= tpc_pkg::VEL_RESET;
            acc_reg   <= tpc_pkg::ACC_RESET;
            total_reg <= tpc_pkg::TOTAL_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tpc_pkg::REG_START: start_reg <= cfg_data;
                tpc_pkg::REG_END:   end_reg   <= cfg_data;
                tpc_pkg::REG_VEL:   vel_reg   <= cfg_data[30:0];
                tpc_pkg::REG_ACC:   acc_reg   <= cfg_data[30:0];
                tpc_pkg::REG_TOTAL: total_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpc_pkg::SEQ_IDLE;
            cnt_reg   <= '0;
            ta_reg    <= tpc_pkg::TA_RESET;
            tc_reg    <= tpc_pkg::TC_RESET;
            hta_reg   <= tpc_pkg::HTA_RESET;
            vtc_reg   <= tpc_pkg::VTC_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ta_reg    <= ta_next;
            tc_reg    <= tc_next;
            hta_reg   <= hta_next;
            vtc_reg   <= vtc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        prod_reg <= prod_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 6'd1;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        prod_next  = {prod_reg[93:0], 1'b0} + (my_reg[33] ? {34'd0, mx_reg} : 95'd0);
        ta_next    = ta_reg;
        tc_next    = tc_reg;
        hta_next   = hta_reg;
        vtc_next   = vtc_reg;

        dividend  = {vel_reg, 16'd0};
        div_bit   = tpc_pkg::DIV_LAST - cnt_reg;
        rem_shift = {rem_reg, dividend[div_bit]};
        quo_bit   = (rem_shift >= {1'b0, acc_reg});
        // quotient including the bit resolved this step
        ta_calc   = (|quo_reg[45:32]) ? tpc_pkg::TA_MAX : {quo_reg[31:0], quo_bit};
        tc_wide   = $signed({3'd0, total_reg}) - $signed({1'b0, ta_calc, 1'b0});
        p_sat     = tpc_pkg::sat60(prod_next[94:16]);
        vt_mag    = prod_next[94:16];

        case (state_reg)
            tpc_pkg::SEQ_IDLE:
            begin
                cnt_next = '0;
            end
            tpc_pkg::SEQ_DIV:
            begin
                rem_next = quo_bit ? 31'(rem_shift - {1'b0, acc_reg}) : rem_shift[30:0];
                quo_next = {quo_reg[45:0], quo_bit};
                if (cnt_reg == tpc_pkg::DIV_LAST)
                begin
                    ta_next = ta_calc;
                    if (tc_wide < -$signed(35'sh2_0000_0000))
                        tc_next = -$signed(34'sh2_0000_0000);
                    else
                        tc_next = tc_wide[33:0];
                    mx_next    = {30'd0, acc_reg};
                    my_next    = {1'b0, ta_calc};
                    prod_next  = '0;
                    cnt_next   = '0;
                    state_next = tpc_pkg::SEQ_MUL_AT;
                end
            end
            tpc_pkg::SEQ_MUL_AT:
            begin
                my_next = {my_reg[32:0], 1'b0};
                if (cnt_reg == tpc_pkg::MUL_LAST)
                begin
                    mx_next    = p_sat;
                    my_next    = {1'b0, ta_reg};
                    prod_next  = '0;
                    cnt_next   = '0;
                    state_next = tpc_pkg::SEQ_MUL_HT;
                end
            end
            tpc_pkg::SEQ_MUL_HT:
            begin
                my_next = {my_reg[32:0], 1'b0};
                if (cnt_reg == tpc_pkg::MUL_LAST)
                begin
                    hta_next   = p_sat[60:1];
                    mx_next    = {30'd0, vel_reg};
                    my_next    = tc_reg[33] ? 34'(-tc_reg) : tc_reg;
                    prod_next  = '0;
                    cnt_next   = '0;
                    state_next = tpc_pkg::SEQ_MUL_VT;
                end
            end
            tpc_pkg::SEQ_MUL_VT:
            begin
                my_next = {my_reg[32:0], 1'b0};
                if (cnt_reg == tpc_pkg::MUL_LAST)
                begin
                    vtc_next   = tc_reg[33] ? -$signed({1'b0, vt_mag[49:0]})
                                            : $signed({1'b0, vt_mag[49:0]});
                    cnt_next   = '0;
                    state_next = tpc_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = tpc_pkg::SEQ_IDLE;
            end
        endcase

        // any write to a defined register restarts the derivation
        if (cfg_hit)
        begin
            state_next = tpc_pkg::SEQ_DIV;
            cnt_next   = '0;
            rem_next   = '0;
            quo_next   = '0;
        end
    end

    // sample pipeline
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

    tpc_pkg::segment_t s1_seg_reg, s2_seg_reg, s3_seg_reg, s4_seg_reg, s5_seg_reg, s6_seg_reg;
    tpc_pkg::segment_t s1_seg_next;
    logic [33:0] s1_u_reg, s1_w_reg, s1_u_next, s1_w_next;
    logic [47:0] s2_au_lo_reg, s2_au_hi_reg, s2_vw_lo_reg, s2_vw_hi_reg;
    logic [33:0] s2_u_reg, s3_u_reg;
    logic [48:0] s3_p_reg, s3_m_reg, s4_m_reg, s5_m_reg;
    logic [64:0] s3_p_next, s3_m_next;
    logic [41:0] s4_pp0_reg, s4_pp1_reg;
    logic [40:0] s4_pp2_reg, s4_pp3_reg;
    logic [59:0] s5_hq_reg;
    logic [82:0] s5_full;
    logic [60:0] s5_hq_next;
    logic signed [62:0] s6_mag_reg, s6_mag_next;
    logic signed [63:0] s7_sum;
    logic signed [31:0] position_reg, position_next;
    tpc_pkg::segment_t  segment_reg;

    logic signed [34:0] ts35, tatc35;
    logic               same_end;

    assign rdy7 = !out_valid_reg || !out_stall;
    assign rdy6 = !v6_reg || rdy7;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign in_stall  = busy || !rdy1;
    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign segment   = segment_reg;

    always_comb
    begin
        same_end = (start_reg == end_reg);
        ts35     = $signed({3'd0, sample_time});
        tatc35   = $signed({2'd0, ta_reg}) + 35'(tc_reg);
        s1_u_next = '0;
        s1_w_next = '0;
        if (same_end)
            s1_seg_next = tpc_pkg::SEG_DONE;
        else if ({1'b0, sample_time} < ta_reg)
        begin
            s1_seg_next = tpc_pkg::SEG_ACCEL;
            s1_u_next   = {2'd0, sample_time};
        end
        else if (ts35 < tatc35)
        begin
            s1_seg_next = tpc_pkg::SEG_CRUISE;
            s1_w_next   = 34'({2'd0, sample_time} - {1'b0, ta_reg});
        end
        else if (sample_time < total_reg)
        begin
            s1_seg_next = tpc_pkg::SEG_DECEL;
            s1_u_next   = 34'(ts35 - tatc35);
            s1_w_next   = 34'(ts35 - tatc35);
        end
        else
            s1_seg_next = tpc_pkg::SEG_DONE;

        s3_p_next = {s2_au_hi_reg, 17'd0} + {17'd0, s2_au_lo_reg};
        s3_m_next = {s2_vw_hi_reg, 17'd0} + {17'd0, s2_vw_lo_reg};

        s5_full = {41'd0, s4_pp0_reg} + {24'd0, s4_pp1_reg, 17'd0}
                + {17'd0, s4_pp2_reg, 25'd0} + {s4_pp3_reg, 42'd0};
        s5_hq_next = tpc_pkg::sat60({12'd0, s5_full[82:16]});

        case (s5_seg_reg)
            tpc_pkg::SEG_ACCEL:
                s6_mag_next = $signed({3'd0, s5_hq_reg});
            tpc_pkg::SEG_CRUISE:
                s6_mag_next = $signed({3'd0, hta_reg}) + $signed({14'd0, s5_m_reg});
            tpc_pkg::SEG_DECEL:
                s6_mag_next = $signed({3'd0, hta_reg}) + $signed({{12{vtc_reg[50]}}, vtc_reg})
                            + $signed({14'd0, s5_m_reg}) - $signed({3'd0, s5_hq_reg});
            default:
                s6_mag_next = '0;
        endcase

        if (end_reg > start_reg)
            s7_sum = 64'(start_reg) + 64'(s6_mag_reg);
        else
            s7_sum = 64'(start_reg) - 64'(s6_mag_reg);
        if (s6_seg_reg == tpc_pkg::SEG_DONE)
            position_next = end_reg;
        else if (s7_sum > 64'sh7FFF_FFFF)
            position_next = 32'sh7FFF_FFFF;
        else if (s7_sum < -64'sh8000_0000)
            position_next = 32'sh8000_0000;
        else
            position_next = s7_sum[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid && !busy;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
            if (rdy7) out_valid_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_seg_reg <= s1_seg_next;
            s1_u_reg   <= s1_u_next;
            s1_w_reg   <= s1_w_next;
        end
        if (rdy2)
        begin
            s2_au_lo_reg <= 48'(acc_reg) * 48'(s1_u_reg[16:0]);
            s2_au_hi_reg <= 48'(acc_reg) * 48'(s1_u_reg[33:17]);
            s2_vw_lo_reg <= 48'(vel_reg) * 48'(s1_w_reg[16:0]);
            s2_vw_hi_reg <= 48'(vel_reg) * 48'(s1_w_reg[33:17]);
            s2_u_reg     <= s1_u_reg;
            s2_seg_reg   <= s1_seg_reg;
        end
        if (rdy3)
        begin
            s3_p_reg   <= s3_p_next[64:16];
            s3_m_reg   <= s3_m_next[64:16];
            s3_u_reg   <= s2_u_reg;
            s3_seg_reg <= s2_seg_reg;
        end
        if (rdy4)
        begin
            s4_pp0_reg <= 42'(s3_p_reg[24:0]) * 42'(s3_u_reg[16:0]);
            s4_pp1_reg <= 42'(s3_p_reg[24:0]) * 42'(s3_u_reg[33:17]);
            s4_pp2_reg <= 41'(s3_p_reg[48:25]) * 41'(s3_u_reg[16:0]);
            s4_pp3_reg <= 41'(s3_p_reg[48:25]) * 41'(s3_u_reg[33:17]);
            s4_m_reg   <= s3_m_reg;
            s4_seg_reg <= s3_seg_reg;
        end
        if (rdy5)
        begin
            s5_hq_reg  <= s5_hq_next[60:1];
            s5_m_reg   <= s4_m_reg;
            s5_seg_reg <= s4_seg_reg;
        end
        if (rdy6)
        begin
            s6_mag_reg <= s6_mag_next;
            s6_seg_reg <= s5_seg_reg;
        end
        if (rdy7)
        begin
            position_reg <= position_next;
            segment_reg  <= s6_seg_reg;
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam longint unsigned PROD_CAP = 64'd1 << 60;
    localparam longint unsigned TA_CAP   = (64'd1 << 33) - 64'd1;
    localparam longint          TC_FLOOR = -(64'sd1 << 33);
    localparam int              LATENCY  = 7;
    localparam longint          CYCLE_LIMIT = 3000000;

    typedef struct {
        logic signed [31:0] position;
        tpc_pkg::segment_t  segment;
    } traj_point_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [31:0]        sample_time;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] position;
    logic [1:0]         segment;

    // shadow of the profile registers and the derived times
    logic signed [31:0] start_q;
    logic signed [31:0] end_q;
    logic [30:0]        vel_q;
    logic [30:0]        acc_q;
    logic [31:0]        total_q;
    longint unsigned    accel_time;
    longint             cruise_time;

    traj_point_t pending_points[$];
    int          fail_count;
    int          burst_left;
    int          stall_mode;
    longint      cycle_count;

    trapezoidal_trajectory_position_core u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_time (sample_time),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .position    (position),
        .segment     (segment)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint unsigned qmul(longint unsigned x, longint unsigned y);
        longint unsigned yh;
        longint unsigned yl;
        longint unsigned xh;
        longint unsigned xl;
        longint unsigned s;
        yh = y >> 16;
        yl = y & 64'hFFFF;
        xh = x >> 16;
        xl = x & 64'hFFFF;
        if (yh != 0 && x > PROD_CAP / yh)
            return PROD_CAP;
        s = x * yh + xh * yl + ((xl * yl) >> 16);
        return (s > PROD_CAP) ? PROD_CAP : s;
    endfunction

    function automatic longint unsigned half_square(longint unsigned a, longint unsigned t);
        return qmul(qmul(a, t), t) >> 1;
    endfunction

    function automatic void derive_times();
        longint unsigned ta;
        if (acc_q == 0)
            ta = TA_CAP;
        else
        begin
            ta = ({33'd0, vel_q} << 16) / {33'd0, acc_q};
            if (ta > TA_CAP)
                ta = TA_CAP;
        end
        accel_time  = ta;
        cruise_time = longint'({32'd0, total_q}) - 2 * longint'(ta);
        if (cruise_time < TC_FLOOR)
            cruise_time = TC_FLOOR;
    endfunction

    function automatic traj_point_t profile_point(logic [31:0] t);
        traj_point_t     p;
        longint          ta;
        longint          tc;
        longint          ts;
        longint          mag;
        longint          q;
        longint          vtc;
        longint unsigned td;
        ta  = longint'(accel_time);
        tc  = cruise_time;
        ts  = longint'({32'd0, t});
        mag = 0;
        if (end_q == start_q)
        begin
            q = end_q;
            p.segment = tpc_pkg::SEG_DONE;
        end
        else
        begin
            if (ts < ta)
            begin
                p.segment = tpc_pkg::SEG_ACCEL;
                mag = longint'(half_square(acc_q, t));
            end
            else if (ts < ta + tc)
            begin
                p.segment = tpc_pkg::SEG_CRUISE;
                mag = longint'(half_square(acc_q, ta)) + longint'(qmul(vel_q, ts - ta));
            end
            else if (t < total_q)
            begin
                p.segment = tpc_pkg::SEG_DECEL;
                td  = ts - ta - tc;
                vtc = (tc < 0) ? -longint'(qmul(vel_q, -tc)) : longint'(qmul(vel_q, tc));
                mag = longint'(half_square(acc_q, ta)) + vtc + longint'(qmul(vel_q, td))
                    - longint'(half_square(acc_q, td));
            end
            else
                p.segment = tpc_pkg::SEG_DONE;
            if (p.segment == tpc_pkg::SEG_DONE)
                q = end_q;
            else if (end_q > start_q)
                q = longint'(start_q) + mag;
            else
                q = longint'(start_q) - mag;
        end
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        p.position = q[31:0];
        return p;
    endfunction

    // one transfer on the sample channel, with bursts and gaps in between
    task automatic send_sample(logic [31:0] t);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge clk);
        in_valid    = 1'b1;
        sample_time = t;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        pending_points.push_back(profile_point(t));
    endtask

    // wait for the pipeline to empty before touching the registers
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_points.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 3) @(negedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            tpc_pkg::REG_START: start_q = data;
            tpc_pkg::REG_END:   end_q   = data;
            tpc_pkg::REG_VEL:   vel_q   = data[30:0];
            tpc_pkg::REG_ACC:   acc_q   = data[30:0];
            tpc_pkg::REG_TOTAL: total_q = data;
            default:            return;
        endcase
        derive_times();
    endtask

    task automatic reg_write_done();
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic set_profile(logic [31:0] s, logic [31:0] e, logic [30:0] v,
                               logic [30:0] a, logic [31:0] tt);
        drain();
        reg_write(tpc_pkg::REG_START, s);
        reg_write(tpc_pkg::REG_END, e);
        reg_write(tpc_pkg::REG_VEL, {1'b0, v});
        reg_write(tpc_pkg::REG_ACC, {1'b0, a});
        reg_write(tpc_pkg::REG_TOTAL, tt);
        reg_write_done();
    endtask

    // points at time zero, just before ta, at ta+tc, on either side of T, and at the top of the time range
    task automatic send_boundaries();
        longint b[6];
        b[0] = 0;
        b[1] = longint'(accel_time) - 1;
        b[2] = longint'(accel_time) + cruise_time;
        b[3] = longint'({32'd0, total_q}) - 1;
        b[4] = longint'({32'd0, total_q});
        b[5] = 64'hFFFF_FFFF;
        foreach (b[i])
        begin
            if (b[i] < 0)
                b[i] = 0;
            if (b[i] > 64'hFFFF_FFFF)
                b[i] = 64'hFFFF_FFFF;
            send_sample(b[i][31:0]);
        end
    endtask

    task automatic test_reset_profile();
        end_q = end_q;
        drain();
        reg_write(tpc_pkg::REG_END, 32'sh0008_0000);
        reg_write_done();
        send_boundaries();
        send_sample(32'h0001_8000);
    endtask

    task automatic test_equal_endpoints();
        set_profile(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'd65536, 31'd65536, 32'd262144);
        send_sample(32'd0);
        send_sample(32'h0002_0000);
    endtask

    task automatic test_zero_acceleration();
        set_profile(32'sh0000_0000, 32'sh8000_0000, 31'd65536, 31'd0, 32'hFFFF_FFFF);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
    endtask

    task automatic test_triangular();
        // 2*ta exceeds T, so cruise is skipped
        set_profile(32'sh8000_0000, 32'sh7FFF_FFFF, 31'h0010_0000, 31'h0000_8000,
                    32'h0010_0000);
        send_boundaries();
    endtask

    task automatic test_saturation();
        set_profile(32'sh7FFF_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 31'd1, 32'h0000_0000);
        send_sample(32'h8000_0000);
        set_profile(32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                    32'hFFFF_FFFF);
        send_boundaries();
    endtask

    task automatic test_bad_index();
        logic [2:0] idx;
        drain();
        for (int i = int'(tpc_pkg::REG_TOTAL) + 1; i < 8; i++)
        begin
            idx = 3'(i);
            reg_write(idx, $urandom());
        end
        reg_write_done();
        send_sample(32'h0000_4000);
        send_sample(32'h0002_0000);
    endtask

    function automatic logic [31:0] pick_position();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            3:       return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [30:0] pick_rate(bit allow_zero);
        case ($urandom_range(0, 7))
            0:       return allow_zero ? 31'd0 : 31'd1;
            1:       return 31'h7FFF_FFFF;
            2:       return 31'd1;
            3:       return 31'($urandom() >> 1);
            default: return 31'($urandom_range(32'h0000_1000, 32'h0010_0000));
        endcase
    endfunction

    task automatic randomise_profile();
        int     picks;
        longint tt;
        logic [2:0] idx;
        drain();
        picks = $urandom_range(1, 31);
        if (picks[0])
            reg_write(tpc_pkg::REG_START, pick_position());
        if (picks[1])
            reg_write(tpc_pkg::REG_END, ($urandom_range(0, 7) == 0) ? start_q : pick_position());
        if (picks[2])
            reg_write(tpc_pkg::REG_VEL, {1'b0, pick_rate(1'b1)});
        if (picks[3])
            reg_write(tpc_pkg::REG_ACC, {1'b0, pick_rate($urandom_range(0, 9) == 0)});
        if (picks[4] || $urandom_range(0, 1))
        begin
            if ($urandom_range(0, 4) == 0 || accel_time > 64'h3FFF_FFFF)
                tt = $urandom();
            else
                tt = 2 * longint'(accel_time)
                   + longint'($urandom_range(0, 32'(4 * accel_time + 2)))
                   - 2 * longint'(accel_time);
            if (tt < 0)
                tt = 0;
            if (tt > 64'hFFFF_FFFF)
                tt = 64'hFFFF_FFFF;
            reg_write(tpc_pkg::REG_TOTAL, tt[31:0]);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            idx = 3'($urandom_range(int'(tpc_pkg::REG_TOTAL) + 1, 7));
            reg_write(idx, $urandom());
        end
        reg_write_done();
    endtask

    task automatic test_random();
        longint span;
        longint t;
        for (int phase = 0; phase < 20; phase++)
        begin
            randomise_profile();
            span = longint'({32'd0, total_q}) + longint'({32'd0, total_q}) / 8 + 16;
            if (span > 64'hFFFF_FFFF)
                span = 64'hFFFF_FFFF;
            for (int n = 0; n < 70; n++)
            begin
                case ($urandom_range(0, 9))
                    0:       t = $urandom();
                    1:       t = longint'(accel_time) + $urandom_range(0, 4) - 2;
                    2:       t = longint'(accel_time) + cruise_time + $urandom_range(0, 4) - 2;
                    3:       t = longint'({32'd0, total_q}) + $urandom_range(0, 4) - 2;
                    default: t = $urandom_range(0, span[31:0]);
                endcase
                if (t < 0)
                    t = 0;
                if (t > 64'hFFFF_FFFF)
                    t = 64'hFFFF_FFFF;
                send_sample(t[31:0]);
            end
        end
    endtask

    // receiver stall pattern, switching among randomly chosen styles
    always @(negedge clk)
    begin
        if (cycle_count % 300 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 9) < 3);
            2:       out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= ((cycle_count % 7) < 2);
        endcase
    end

    always @(posedge clk)
    begin
        traj_point_t exp_pt;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_points.size() == 0)
            begin
                $error("unexpected transfer: position %0d segment %0d", position, segment);
                fail_count++;
            end
            else
            begin
                exp_pt = pending_points.pop_front();
                if (position !== exp_pt.position)
                begin
                    $error("position: expected %0d, actual %0d", exp_pt.position, position);
                    fail_count++;
                end
                if (segment !== exp_pt.segment)
                begin
                    $error("segment: expected %0d, actual %0d", exp_pt.segment, segment);
                    fail_count++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
        stall_mode  = 0;
        fail_count  = 0;
        burst_left  = 0;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = tpc_pkg::REG_START;
        cfg_data    = 32'd0;
        in_valid    = 1'b0;
        sample_time = 32'd0;
        out_stall   = 1'b0;
        start_q     = 32'sd0;
        end_q       = 32'sd0;
        vel_q       = tpc_pkg::VEL_RESET;
        acc_q       = tpc_pkg::ACC_RESET;
        total_q     = tpc_pkg::TOTAL_RESET;
        derive_times();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_profile();
        test_equal_endpoints();
        test_zero_acceleration();
        test_triangular();
        test_saturation();
        test_bad_index();
        test_random();
        drain();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
